>>> rtl/msct_pkg.sv
// msct_pkg: shared types, codes and the direction decode of the contour tracer
// no dependencies
package msct_pkg;

	// coordinate width of corners and cells in the control path
	localparam int CW = 7;

	// request kinds on the input tuser
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_START = 2'd2;
	localparam logic [1:0] REQ_STEP  = 2'd3;

	// result status codes on the output tuser
	localparam logic [2:0] ST_ACK    = 3'd0;
	localparam logic [2:0] ST_POINT  = 3'd1;
	localparam logic [2:0] ST_CLOSED = 3'd2;
	localparam logic [2:0] ST_NONE   = 3'd3;
	localparam logic [2:0] ST_NOISE  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_BLOCK  = 2'd2;

	typedef enum logic [2:0] {
		DIR_NONE,
		DIR_UP,
		DIR_DOWN,
		DIR_LEFT,
		DIR_RIGHT
	} dir_t;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_SCAN,
		S_SCHK,
		S_NBR,
		S_DIR,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [6:0] grid_width;
		logic [6:0] grid_height;
		logic [8:0] block_size;
	} cfg_t;

	typedef struct packed {
		logic sol_we;
		logic sol_wd;
		logic vis_we;
		logic vis_wd;
	} mem_cmd_t;

	// marching squares move from the 2x2 neighbourhood code (UL=1 UR=2 DL=4 DR=8)
	function automatic dir_t next_dir(input logic [3:0] code, input dir_t prev);
		dir_t d;
		d = DIR_NONE;
		case (code) inside
			4'd1, 4'd5, 4'd13: d = DIR_UP;
			4'd2, 4'd3, 4'd7: d = DIR_RIGHT;
			4'd4, 4'd12, 4'd14: d = DIR_LEFT;
			4'd8, 4'd10, 4'd11: d = DIR_DOWN;
			4'd6: d = (prev == DIR_UP) ? DIR_LEFT : DIR_RIGHT;
			4'd9: d = (prev == DIR_RIGHT) ? DIR_UP : DIR_DOWN;
			default: d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

>>> rtl/msct_cfg.sv
// msct_cfg: configuration registers behind the apb-style port
// depends on msct_pkg
module msct_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output msct_pkg::cfg_t     cfg
);

	logic [6:0] width_q;
	logic [6:0] height_q;
	logic [8:0] block_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 7'd64;
			height_q <= 7'd64;
			block_q  <= 9'd32;
		end else if (wr_en) begin
			case (paddr[3:2])
				msct_pkg::REG_WIDTH:  width_q  <= pwdata[6:0];
				msct_pkg::REG_HEIGHT: height_q <= pwdata[6:0];
				msct_pkg::REG_BLOCK:  block_q  <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (paddr[3:2])
			msct_pkg::REG_WIDTH:  prdata = {25'd0, width_q};
			msct_pkg::REG_HEIGHT: prdata = {25'd0, height_q};
			msct_pkg::REG_BLOCK:  prdata = {23'd0, block_q};
			default:              prdata = 32'd0;
		endcase
	end

	assign cfg.grid_width  = width_q;
	assign cfg.grid_height = height_q;
	assign cfg.block_size  = block_q;

endmodule

>>> rtl/msct_mem.sv
// msct_mem: solid cell map and visited corner map, one registered read port each
// depends on msct_pkg
module msct_mem #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                   clk,
	input  msct_pkg::mem_cmd_t     cmd,
	input  logic [$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0]     sol_addr,
	input  logic [$clog2(MAX_COLUMNS+1)+$clog2(MAX_ROWS+1)-1:0] vis_addr,
	output logic                   sol_rd,
	output logic                   vis_rd
);

	localparam int SAW = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);
	localparam int VAW = $clog2(MAX_COLUMNS + 1) + $clog2(MAX_ROWS + 1);

	logic sol_mem [1 << SAW];
	logic vis_mem [1 << VAW];

	// solid map
	always_ff @(posedge clk) begin
		if (cmd.sol_we) begin
			sol_mem[sol_addr] <= cmd.sol_wd;
		end
		sol_rd <= sol_mem[sol_addr];
	end

	// visited map
	always_ff @(posedge clk) begin
		if (cmd.vis_we) begin
			vis_mem[vis_addr] <= cmd.vis_wd;
		end
		vis_rd <= vis_mem[vis_addr];
	end

endmodule

>>> rtl/msct_ctrl.sv
// msct_ctrl: request sequencer, search scan, neighbour reads and output register
// depends on msct_pkg
module msct_ctrl #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  msct_pkg::cfg_t         cfg,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [15:0]            s_tdata,
	input  logic [1:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [47:0]            m_tdata,
	output logic [2:0]             m_tuser,
	output msct_pkg::mem_cmd_t     cmd,
	output logic [$clog2(MAX_COLUMNS)+$clog2(MAX_ROWS)-1:0]     sol_addr,
	output logic [$clog2(MAX_COLUMNS+1)+$clog2(MAX_ROWS+1)-1:0] vis_addr,
	input  logic                   sol_rd,
	input  logic                   vis_rd
);

	localparam int CW  = msct_pkg::CW;
	localparam int XW  = $clog2(MAX_COLUMNS);
	localparam int YW  = $clog2(MAX_ROWS);
	localparam int VXW = $clog2(MAX_COLUMNS + 1);
	localparam int VYW = $clog2(MAX_ROWS + 1);
	localparam int VAW = VXW + VYW;

	msct_pkg::state_t state_q, state_d;
	msct_pkg::dir_t   last_q, dir_c;

	logic [VAW-1:0] cnt_q;
	logic           clr_mode_q;
	logic [1:0]     req_q;
	logic [CW-1:0]  x_q, y_q, cur_x_q, cur_y_q, org_x_q, org_y_q;
	logic           tracing_q;
	logic [2:0]     nb_q;
	logic [3:0]     code_q;
	logic           inr_s1;
	logic [CW-1:0]  rx_q, ry_q, rsx_q, rsy_q;
	logic           rpt_q;
	logic [2:0]     rst_q;
	logic           out_valid_q;
	logic [14:0]    out_px_q, out_py_q;
	logic [CW-1:0]  out_sx_q, out_sy_q;
	logic [2:0]     out_st_q;

	logic [CW-1:0]  eff_w, eff_h, sx_c, sy_c;
	logic           in_acc, out_free, sweep_end;
	logic [5:0]     in_x, in_y;
	logic           in_solid, load_ok;
	logic [CW-1:0]  nbx, nby, nx_c, ny_c;
	logic           nb_in;
	logic [15:0]    prod_x, prod_y;

	// effective grid size and the start fields: the origin while tracing, the grid size when idle
	assign eff_w = (32'(cfg.grid_width) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : cfg.grid_width;
	assign eff_h = (32'(cfg.grid_height) > MAX_ROWS) ? CW'(MAX_ROWS) : cfg.grid_height;
	assign sx_c  = tracing_q ? org_x_q : eff_w;
	assign sy_c  = tracing_q ? org_y_q : eff_h;

	assign in_x     = s_tdata[5:0];
	assign in_y     = s_tdata[11:6];
	assign in_solid = s_tdata[12];
	assign load_ok  = (32'(in_x) < MAX_COLUMNS) && (32'(in_y) < MAX_ROWS);

	assign s_tready  = (state_q == msct_pkg::S_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign sweep_end = (cnt_q == {VAW{1'b1}});

	// neighbour cell of the current read, outside the grid reads as empty
	assign nbx   = nb_q[0] ? x_q : x_q - CW'(1);
	assign nby   = nb_q[1] ? y_q : y_q - CW'(1);
	assign nb_in = (nb_q[0] || (x_q != '0)) && (nb_q[1] || (y_q != '0))
		&& (nbx < eff_w) && (nby < eff_h);

	// move decision and the corner it leads to
	assign dir_c = msct_pkg::next_dir(code_q,
		(req_q == msct_pkg::REQ_STEP) ? last_q : msct_pkg::DIR_NONE);
	always_comb begin
		nx_c = x_q;
		ny_c = y_q;
		case (dir_c)
			msct_pkg::DIR_UP:    ny_c = y_q - CW'(1);
			msct_pkg::DIR_DOWN:  ny_c = y_q + CW'(1);
			msct_pkg::DIR_LEFT:  nx_c = x_q - CW'(1);
			msct_pkg::DIR_RIGHT: nx_c = x_q + CW'(1);
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msct_pkg::S_SWEEP: if (sweep_end) state_d = clr_mode_q ? msct_pkg::S_EMIT
				: msct_pkg::S_IDLE;
			msct_pkg::S_IDLE: begin
				if (in_acc) begin
					case (s_tuser)
						msct_pkg::REQ_CLEAR: state_d = msct_pkg::S_SWEEP;
						msct_pkg::REQ_START: state_d = msct_pkg::S_SCAN;
						msct_pkg::REQ_STEP: state_d = tracing_q ? msct_pkg::S_NBR
							: msct_pkg::S_EMIT;
						default: state_d = msct_pkg::S_EMIT;
					endcase
				end
			end
			msct_pkg::S_SCAN: begin
				if (x_q >= eff_w) state_d = msct_pkg::S_EMIT;
				else if (y_q < eff_h) state_d = msct_pkg::S_SCHK;
			end
			msct_pkg::S_SCHK: state_d = (sol_rd && !vis_rd) ? msct_pkg::S_NBR
				: msct_pkg::S_SCAN;
			msct_pkg::S_NBR: if (nb_q == 3'd4) state_d = msct_pkg::S_DIR;
			msct_pkg::S_DIR: state_d = msct_pkg::S_EMIT;
			msct_pkg::S_EMIT: if (out_free) state_d = msct_pkg::S_IDLE;
			default: state_d = msct_pkg::S_IDLE;
		endcase
	end

	// memory addresses and write strobes
	always_comb begin
		cmd      = '0;
		sol_addr = {YW'(y_q), XW'(x_q)};
		vis_addr = {VYW'(y_q), VXW'(x_q)};
		case (state_q)
			msct_pkg::S_SWEEP: begin
				sol_addr   = cnt_q[XW+YW-1:0];
				vis_addr   = cnt_q;
				cmd.sol_we = !clr_mode_q;
				cmd.vis_we = 1'b1;
			end
			msct_pkg::S_IDLE: begin
				sol_addr   = {YW'(in_y), XW'(in_x)};
				cmd.sol_we = in_acc && (s_tuser == msct_pkg::REQ_LOAD) && load_ok;
				cmd.sol_wd = in_solid;
			end
			msct_pkg::S_NBR: sol_addr = {YW'(nby), XW'(nbx)};
			msct_pkg::S_DIR: begin
				cmd.vis_wd = 1'b1;
				if (req_q == msct_pkg::REQ_START) begin
					cmd.vis_we = 1'b1;
				end else if (dir_c != msct_pkg::DIR_NONE
						&& !(nx_c == org_x_q && ny_c == org_y_q)
						&& nx_c <= eff_w && ny_c <= eff_h) begin
					vis_addr   = {VYW'(ny_c), VXW'(nx_c)};
					cmd.vis_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msct_pkg::S_SWEEP;
			cnt_q       <= '0;
			clr_mode_q  <= 1'b0;
			tracing_q   <= 1'b0;
			last_q      <= msct_pkg::DIR_NONE;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			org_x_q     <= '0;
			org_y_q     <= '0;
			nb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// output word held until taken, reloaded from the emit state
			if (state_q == msct_pkg::S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				msct_pkg::S_SWEEP: cnt_q <= cnt_q + VAW'(1);
				msct_pkg::S_IDLE: begin
					nb_q <= '0;
					if (in_acc && s_tuser == msct_pkg::REQ_CLEAR) begin
						clr_mode_q <= 1'b1;
						cnt_q      <= '0;
					end
					if (in_acc && s_tuser == msct_pkg::REQ_START) tracing_q <= 1'b0;
				end
				msct_pkg::S_NBR: nb_q <= nb_q + 3'd1;
				msct_pkg::S_DIR: begin
					if (req_q == msct_pkg::REQ_START) begin
						if (dir_c != msct_pkg::DIR_NONE) begin
							tracing_q <= 1'b1;
							last_q    <= msct_pkg::DIR_NONE;
							cur_x_q   <= x_q;
							cur_y_q   <= y_q;
							org_x_q   <= x_q;
							org_y_q   <= y_q;
						end
					end else if (dir_c == msct_pkg::DIR_NONE) begin
						tracing_q <= 1'b0;
					end else begin
						last_q  <= dir_c;
						cur_x_q <= nx_c;
						cur_y_q <= ny_c;
						if (nx_c == org_x_q && ny_c == org_y_q) tracing_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// request data, scan position and result staging
	always_ff @(posedge clk) begin
		inr_s1 <= nb_in;
		case (state_q)
			msct_pkg::S_SWEEP: begin
				rpt_q <= 1'b0;
				rst_q <= msct_pkg::ST_ACK;
				rsx_q <= sx_c;
				rsy_q <= sy_c;
			end
			msct_pkg::S_IDLE: begin
				req_q <= s_tuser;
				rpt_q <= 1'b0;
				rst_q <= msct_pkg::ST_ACK;
				rsx_q <= (s_tuser == msct_pkg::REQ_START) ? eff_w : sx_c;
				rsy_q <= (s_tuser == msct_pkg::REQ_START) ? eff_h : sy_c;
				if (s_tuser == msct_pkg::REQ_STEP) begin
					x_q <= cur_x_q;
					y_q <= cur_y_q;
				end else begin
					x_q <= CW'(in_x);
					y_q <= CW'(in_y);
				end
			end
			msct_pkg::S_SCAN: begin
				rst_q <= msct_pkg::ST_NONE;
				if (x_q < eff_w && y_q >= eff_h) begin
					x_q <= x_q + CW'(1);
					y_q <= '0;
				end
			end
			msct_pkg::S_SCHK: if (!(sol_rd && !vis_rd)) y_q <= y_q + CW'(1);
			msct_pkg::S_NBR: if (nb_q != 3'd0) code_q[2'(nb_q - 3'd1)] <= sol_rd && inr_s1;
			msct_pkg::S_DIR: begin
				rpt_q <= 1'b1;
				rx_q  <= x_q;
				ry_q  <= y_q;
				if (req_q == msct_pkg::REQ_START) begin
					if (dir_c == msct_pkg::DIR_NONE) begin
						rst_q <= msct_pkg::ST_NOISE;
					end else begin
						rst_q <= msct_pkg::ST_POINT;
						rsx_q <= x_q;
						rsy_q <= y_q;
					end
				end else begin
					rsx_q <= org_x_q;
					rsy_q <= org_y_q;
					if (dir_c == msct_pkg::DIR_NONE) begin
						rst_q <= msct_pkg::ST_NOISE;
					end else begin
						rx_q  <= nx_c;
						ry_q  <= ny_c;
						rst_q <= (nx_c == org_x_q && ny_c == org_y_q) ? msct_pkg::ST_CLOSED
							: msct_pkg::ST_POINT;
					end
				end
			end
			default: ;
		endcase
	end

	// scale the corner by the block size on the way into the output register
	assign prod_x = rx_q * cfg.block_size;
	assign prod_y = ry_q * cfg.block_size;

	always_ff @(posedge clk) begin
		if (state_q == msct_pkg::S_EMIT && out_free) begin
			out_px_q <= rpt_q ? prod_x[14:0] : 15'd0;
			out_py_q <= rpt_q ? prod_y[14:0] : 15'd0;
			out_sx_q <= rsx_q;
			out_sy_q <= rsy_q;
			out_st_q <= rst_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_sy_q, out_sx_q, out_py_q, out_px_q};
	assign m_tuser  = out_st_q;

endmodule

>>> rtl/marching_squares_contour_tracer_top.sv
// clear sweeps the visited map, with one write per cycle into the visited memory port
// one request in flight; the next is taken while the result waits in the output register
// reset: asynchronous, then a sweep clears both maps with s_tready low
module marching_squares_contour_tracer_top #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // cell_x[5:0], cell_y[11:6], cell_solid[12], zero pad
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // point_x[14:0], point_y[29:15], start_x[36:30],
	                               // start_y[43:37], zero pad
	output logic [2:0]  m_tuser,   // status[2:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SAW = $clog2(MAX_COLUMNS) + $clog2(MAX_ROWS);
	localparam int VAW = $clog2(MAX_COLUMNS + 1) + $clog2(MAX_ROWS + 1);

	msct_pkg::cfg_t     cfg;
	msct_pkg::mem_cmd_t cmd;
	logic [SAW-1:0]     sol_addr;
	logic [VAW-1:0]     vis_addr;
	logic               sol_rd, vis_rd;

	msct_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	msct_mem #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_mem (
		.clk(clk), .cmd(cmd), .sol_addr(sol_addr), .vis_addr(vis_addr),
		.sol_rd(sol_rd), .vis_rd(vis_rd)
	);

	msct_ctrl #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cmd(cmd), .sol_addr(sol_addr), .vis_addr(vis_addr),
		.sol_rd(sol_rd), .vis_rd(vis_rd)
	);

endmodule

>>> rtl/msct_chk.sv
// msct_chk: port-level checks of the contour tracer result stream
// depends on msct_pkg and binds to marching_squares_contour_tracer_top
module msct_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	// an ack carries no point
	a_ack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == msct_pkg::ST_ACK |-> m_tdata[29:0] == 30'd0)
		else $error("ack word carries a point");

	// a failed search carries no point
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == msct_pkg::ST_NONE |-> m_tdata[29:0] == 30'd0)
		else $error("no-start word carries a point");

endmodule

bind marching_squares_contour_tracer_top msct_chk u_chk (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
